// ===== rtl/stvk_pkg.sv =====
`timescale 1ns / 1ps
package stvk_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned ModW    = 24;
    localparam int unsigned AreaW   = 31;
    localparam int unsigned RndW    = 48;
    localparam int unsigned ProdW   = 57;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned Rows    = 3;

    localparam logic [CfgIdxW-1:0] CfgShear = 8'd0;
    localparam logic [CfgIdxW-1:0] CfgBulk  = 8'd1;

    localparam logic [ModW-1:0] ShearReset = 24'd19661;
    localparam logic [ModW-1:0] BulkReset  = 24'd98304;

    localparam logic signed [63:0] QOne    = 64'sd65536;
    localparam logic signed [63:0] WordMax = 64'sd2147483647;
    localparam logic signed [63:0] WordMin = -64'sd2147483648;

    typedef logic signed [WordW-1:0] t_word;
    typedef logic signed [RndW-1:0]  t_rnd;
    typedef logic signed [ProdW-1:0] t_prod;

    typedef struct packed {
        t_word f0;
        t_word f1;
    } t_frow;

    typedef struct packed {
        t_word s00;
        t_word s01;
        t_word s11;
        t_word tr;
    } t_strain;

    function automatic logic signed [63:0] mulw(input t_word a, input t_word b);
        return 64'(a) * 64'(b);
    endfunction

    function automatic t_rnd rnd16(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd32768) >>> 16;
        return s[RndW-1:0];
    endfunction

    function automatic t_rnd rnd17(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd65536) >>> 17;
        return s[RndW-1:0];
    endfunction

    function automatic t_word sat32(input logic signed [63:0] v);
        t_word r;
        if (v > WordMax) begin
            r = 32'h7FFF_FFFF;
        end else if (v < WordMin) begin
            r = 32'h8000_0000;
        end else begin
            r = v[WordW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/stvk_strain.sv =====
`timescale 1ns / 1ps
module stvk_strain (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  stvk_pkg::t_word       i_e1 [stvk_pkg::Rows],
    input  stvk_pkg::t_word       i_e2 [stvk_pkg::Rows],
    input  stvk_pkg::t_word       i_inv_00,
    input  stvk_pkg::t_word       i_inv_01,
    input  stvk_pkg::t_word       i_inv_10,
    input  stvk_pkg::t_word       i_inv_11,
    output logic                  o_valid,
    output stvk_pkg::t_frow       o_f [stvk_pkg::Rows],
    output stvk_pkg::t_strain     o_strain
);

    logic             r_v1, r_v2, r_v3, r_v4, r_v5;
    stvk_pkg::t_rnd   r_pa [stvk_pkg::Rows];
    stvk_pkg::t_rnd   r_pb [stvk_pkg::Rows];
    stvk_pkg::t_rnd   r_pc [stvk_pkg::Rows];
    stvk_pkg::t_rnd   r_pd [stvk_pkg::Rows];
    stvk_pkg::t_frow  r_f2 [stvk_pkg::Rows];
    stvk_pkg::t_frow  r_f3 [stvk_pkg::Rows];
    stvk_pkg::t_frow  r_f4 [stvk_pkg::Rows];
    stvk_pkg::t_frow  r_f5 [stvk_pkg::Rows];
    stvk_pkg::t_rnd   r_q00 [stvk_pkg::Rows];
    stvk_pkg::t_rnd   r_q01 [stvk_pkg::Rows];
    stvk_pkg::t_rnd   r_q11 [stvk_pkg::Rows];
    stvk_pkg::t_word  r_c00, r_c01, r_c11;
    stvk_pkg::t_strain r_s;
    logic signed [63:0] n_s00, n_s11, n_s01;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_comb begin
        n_s00 = (64'(r_c00) - stvk_pkg::QOne + 64'sd1) >>> 1;
        n_s11 = (64'(r_c11) - stvk_pkg::QOne + 64'sd1) >>> 1;
        n_s01 = (64'(r_c01) + 64'sd1) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < stvk_pkg::Rows; r++) begin
            r_pa[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(i_e1[r], i_inv_00));
            r_pc[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(i_e2[r], i_inv_10));
            r_pb[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(i_e1[r], i_inv_01));
            r_pd[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(i_e2[r], i_inv_11));
            r_f2[r].f0 <= stvk_pkg::sat32(64'(r_pa[r]) + 64'(r_pc[r]));
            r_f2[r].f1 <= stvk_pkg::sat32(64'(r_pb[r]) + 64'(r_pd[r]));
            r_q00[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_f2[r].f0, r_f2[r].f0));
            r_q01[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_f2[r].f0, r_f2[r].f1));
            r_q11[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_f2[r].f1, r_f2[r].f1));
            r_f3[r] <= r_f2[r];
            r_f4[r] <= r_f3[r];
            r_f5[r] <= r_f4[r];
        end
        r_c00 <= stvk_pkg::sat32(64'(r_q00[0]) + 64'(r_q00[1]) + 64'(r_q00[2]));
        r_c01 <= stvk_pkg::sat32(64'(r_q01[0]) + 64'(r_q01[1]) + 64'(r_q01[2]));
        r_c11 <= stvk_pkg::sat32(64'(r_q11[0]) + 64'(r_q11[1]) + 64'(r_q11[2]));
        r_s.s00 <= n_s00[31:0];
        r_s.s11 <= n_s11[31:0];
        r_s.s01 <= n_s01[31:0];
        r_s.tr  <= stvk_pkg::sat32(n_s00 + n_s11);
    end

    assign o_valid  = r_v5;
    assign o_f      = r_f5;
    assign o_strain = r_s;

endmodule

// ===== rtl/stvk_triangle_energy_gradient_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// input     in         start, busy               edges, rest inverse, rest area
// result    out        o_result_valid strobe     weighted energy, nine gradients
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// A triangle is taken in every cycle; busy stays low.
// Each result is strobed after the 13 register stages of the multiply chain F, F'F,
// stress, area scaling, P and the back product with the rest inverse.
// Reset is synchronous and loads the moduli with their default values.
// Results are never stalled: the receiver takes each strobe as it comes.
module stvk_triangle_energy_gradient_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            i_edge1_x,
    input  logic signed [31:0]            i_edge1_y,
    input  logic signed [31:0]            i_edge1_z,
    input  logic signed [31:0]            i_edge2_x,
    input  logic signed [31:0]            i_edge2_y,
    input  logic signed [31:0]            i_edge2_z,
    input  logic signed [31:0]            i_inv_00,
    input  logic signed [31:0]            i_inv_01,
    input  logic signed [31:0]            i_inv_10,
    input  logic signed [31:0]            i_inv_11,
    input  logic [30:0]                   i_rest_area,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [7:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_result_valid,
    output logic signed [31:0]            o_weighted_energy,
    output logic signed [31:0]            o_grad_v0_x,
    output logic signed [31:0]            o_grad_v1_x,
    output logic signed [31:0]            o_grad_v2_x,
    output logic signed [31:0]            o_grad_v0_y,
    output logic signed [31:0]            o_grad_v1_y,
    output logic signed [31:0]            o_grad_v2_y,
    output logic signed [31:0]            o_grad_v0_z,
    output logic signed [31:0]            o_grad_v1_z,
    output logic signed [31:0]            o_grad_v2_z
);

    localparam int unsigned InvDepth  = 11;
    localparam int unsigned AreaDepth = 9;

    logic [stvk_pkg::ModW-1:0] r_shear, r_bulk;
    stvk_pkg::t_word w_mu, w_k;

    stvk_pkg::t_word   w_e1 [stvk_pkg::Rows];
    stvk_pkg::t_word   w_e2 [stvk_pkg::Rows];
    logic              w_strain_valid;
    stvk_pkg::t_frow   w_f [stvk_pkg::Rows];
    stvk_pkg::t_strain w_s;

    stvk_pkg::t_word r_inv00 [InvDepth];
    stvk_pkg::t_word r_inv01 [InvDepth];
    stvk_pkg::t_word r_inv10 [InvDepth];
    stvk_pkg::t_word r_inv11 [InvDepth];
    logic [stvk_pkg::AreaW-1:0] r_area [AreaDepth];

    logic r_v6, r_v7, r_v8, r_v9, r_v10, r_v11, r_v12, r_v13;

    stvk_pkg::t_frow r_f6 [stvk_pkg::Rows];
    stvk_pkg::t_frow r_f7 [stvk_pkg::Rows];
    stvk_pkg::t_frow r_f8 [stvk_pkg::Rows];
    stvk_pkg::t_frow r_f9 [stvk_pkg::Rows];

    stvk_pkg::t_rnd  r_q00, r_q01, r_q11, r_tt;
    stvk_pkg::t_prod r_m0, r_m1, r_m3, r_kt;
    stvk_pkg::t_word r_qsum, r_tsq, r_x0, r_x1, r_x3;
    stvk_pkg::t_rnd  r_mq, r_kq, r_ax0, r_ax1, r_ax3;
    stvk_pkg::t_word r_energy, r_d0, r_d1, r_d3;
    stvk_pkg::t_rnd  r_we;
    stvk_pkg::t_rnd  r_pa [stvk_pkg::Rows];
    stvk_pkg::t_rnd  r_pb [stvk_pkg::Rows];
    stvk_pkg::t_rnd  r_pc [stvk_pkg::Rows];
    stvk_pkg::t_rnd  r_pd [stvk_pkg::Rows];
    stvk_pkg::t_word r_wen11, r_wen12;
    stvk_pkg::t_frow r_p [stvk_pkg::Rows];
    stvk_pkg::t_rnd  r_g1a [stvk_pkg::Rows];
    stvk_pkg::t_rnd  r_g1b [stvk_pkg::Rows];
    stvk_pkg::t_rnd  r_g2a [stvk_pkg::Rows];
    stvk_pkg::t_rnd  r_g2b [stvk_pkg::Rows];
    stvk_pkg::t_word r_g0o [stvk_pkg::Rows];
    stvk_pkg::t_word r_g1o [stvk_pkg::Rows];
    stvk_pkg::t_word r_g2o [stvk_pkg::Rows];
    stvk_pkg::t_word r_wen13;

    logic signed [63:0] n_g1 [stvk_pkg::Rows];
    logic signed [63:0] n_g2 [stvk_pkg::Rows];
    stvk_pkg::t_word    w_area10;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_mu        = stvk_pkg::t_word'({8'd0, r_shear});
    assign w_k         = stvk_pkg::t_word'({8'd0, r_bulk});
    assign w_area10    = stvk_pkg::t_word'({1'b0, r_area[AreaDepth-1]});

    assign w_e1[0] = i_edge1_x;
    assign w_e1[1] = i_edge1_y;
    assign w_e1[2] = i_edge1_z;
    assign w_e2[0] = i_edge2_x;
    assign w_e2[1] = i_edge2_y;
    assign w_e2[2] = i_edge2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shear <= stvk_pkg::ShearReset;
            r_bulk  <= stvk_pkg::BulkReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stvk_pkg::CfgShear: r_shear <= i_cfg_data[stvk_pkg::ModW-1:0];
                stvk_pkg::CfgBulk:  r_bulk  <= i_cfg_data[stvk_pkg::ModW-1:0];
                default: ;
            endcase
        end
    end

    stvk_strain u_strain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start & ~busy),
        .i_e1     (w_e1),
        .i_e2     (w_e2),
        .i_inv_00 (i_inv_00),
        .i_inv_01 (i_inv_01),
        .i_inv_10 (i_inv_10),
        .i_inv_11 (i_inv_11),
        .o_valid  (w_strain_valid),
        .o_f      (w_f),
        .o_strain (w_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
            r_v12 <= 1'b0;
            r_v13 <= 1'b0;
        end else begin
            r_v6  <= w_strain_valid;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
            r_v11 <= r_v10;
            r_v12 <= r_v11;
            r_v13 <= r_v12;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inv00[0] <= i_inv_00;
        r_inv01[0] <= i_inv_01;
        r_inv10[0] <= i_inv_10;
        r_inv11[0] <= i_inv_11;
        r_area[0]  <= i_rest_area;
        for (int i = 1; i < InvDepth; i++) begin
            r_inv00[i] <= r_inv00[i-1];
            r_inv01[i] <= r_inv01[i-1];
            r_inv10[i] <= r_inv10[i-1];
            r_inv11[i] <= r_inv11[i-1];
        end
        for (int i = 1; i < AreaDepth; i++) begin
            r_area[i] <= r_area[i-1];
        end
    end

    always_comb begin
        for (int r = 0; r < stvk_pkg::Rows; r++) begin
            n_g1[r] = 64'(r_g1a[r]) + 64'(r_g1b[r]);
            n_g2[r] = 64'(r_g2a[r]) + 64'(r_g2b[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q00 <= stvk_pkg::rnd16(stvk_pkg::mulw(w_s.s00, w_s.s00));
        r_q01 <= stvk_pkg::rnd16(stvk_pkg::mulw(w_s.s01, w_s.s01));
        r_q11 <= stvk_pkg::rnd16(stvk_pkg::mulw(w_s.s11, w_s.s11));
        r_tt  <= stvk_pkg::rnd16(stvk_pkg::mulw(w_s.tr, w_s.tr));
        r_m0  <= stvk_pkg::ProdW'(stvk_pkg::mulw(w_mu, w_s.s00));
        r_m1  <= stvk_pkg::ProdW'(stvk_pkg::mulw(w_mu, w_s.s01));
        r_m3  <= stvk_pkg::ProdW'(stvk_pkg::mulw(w_mu, w_s.s11));
        r_kt  <= stvk_pkg::ProdW'(stvk_pkg::mulw(w_k, w_s.tr));

        r_qsum <= stvk_pkg::sat32(64'(r_q00) + (64'(r_q01) <<< 1) + 64'(r_q11));
        r_tsq  <= stvk_pkg::sat32(64'(r_tt));
        r_x0   <= stvk_pkg::sat32(64'(stvk_pkg::rnd16((64'(r_m0) <<< 1) + 64'(r_kt))));
        r_x3   <= stvk_pkg::sat32(64'(stvk_pkg::rnd16((64'(r_m3) <<< 1) + 64'(r_kt))));
        r_x1   <= stvk_pkg::sat32(64'(stvk_pkg::rnd16(64'(r_m1) <<< 1)));

        r_mq  <= stvk_pkg::rnd16(stvk_pkg::mulw(w_mu, r_qsum));
        r_kq  <= stvk_pkg::rnd17(stvk_pkg::mulw(w_k, r_tsq));
        r_ax0 <= stvk_pkg::rnd16(stvk_pkg::mulw(
                     stvk_pkg::t_word'({1'b0, r_area[AreaDepth-3]}), r_x0));
        r_ax1 <= stvk_pkg::rnd16(stvk_pkg::mulw(
                     stvk_pkg::t_word'({1'b0, r_area[AreaDepth-3]}), r_x1));
        r_ax3 <= stvk_pkg::rnd16(stvk_pkg::mulw(
                     stvk_pkg::t_word'({1'b0, r_area[AreaDepth-3]}), r_x3));

        r_energy <= stvk_pkg::sat32(64'(r_mq) + 64'(r_kq));
        r_d0     <= stvk_pkg::sat32(64'(r_ax0));
        r_d1     <= stvk_pkg::sat32(64'(r_ax1));
        r_d3     <= stvk_pkg::sat32(64'(r_ax3));

        r_we <= stvk_pkg::rnd16(stvk_pkg::mulw(w_area10, r_energy));
        r_wen11 <= stvk_pkg::sat32(64'(r_we));
        r_wen12 <= r_wen11;
        r_wen13 <= r_wen12;

        for (int r = 0; r < stvk_pkg::Rows; r++) begin
            r_f6[r] <= w_f[r];
            r_f7[r] <= r_f6[r];
            r_f8[r] <= r_f7[r];
            r_f9[r] <= r_f8[r];
            r_pa[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_d0, r_f9[r].f0));
            r_pb[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_d1, r_f9[r].f1));
            r_pc[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_d1, r_f9[r].f0));
            r_pd[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_d3, r_f9[r].f1));
            r_p[r].f0 <= stvk_pkg::sat32(64'(r_pa[r]) + 64'(r_pb[r]));
            r_p[r].f1 <= stvk_pkg::sat32(64'(r_pc[r]) + 64'(r_pd[r]));
            r_g1a[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_p[r].f0, r_inv00[InvDepth-1]));
            r_g1b[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_p[r].f1, r_inv01[InvDepth-1]));
            r_g2a[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_p[r].f0, r_inv10[InvDepth-1]));
            r_g2b[r] <= stvk_pkg::rnd16(stvk_pkg::mulw(r_p[r].f1, r_inv11[InvDepth-1]));
            r_g1o[r] <= stvk_pkg::sat32(n_g1[r]);
            r_g2o[r] <= stvk_pkg::sat32(n_g2[r]);
            r_g0o[r] <= stvk_pkg::sat32(-(n_g1[r] + n_g2[r]));
        end
    end

    assign o_result_valid    = r_v13;
    assign o_weighted_energy = r_wen13;
    assign o_grad_v0_x       = r_g0o[0];
    assign o_grad_v1_x       = r_g1o[0];
    assign o_grad_v2_x       = r_g2o[0];
    assign o_grad_v0_y       = r_g0o[1];
    assign o_grad_v1_y       = r_g1o[1];
    assign o_grad_v2_y       = r_g2o[1];
    assign o_grad_v0_z       = r_g0o[2];
    assign o_grad_v1_z       = r_g1o[2];
    assign o_grad_v2_z       = r_g2o[2];

    a_result_from_strain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_strain_valid, 8))
        else $error("result strobe without a matching strain stage item");

    a_zero_area_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v9 && r_area[AreaDepth-1] == '0) |=> ##3
        (o_weighted_energy == '0 && o_grad_v1_x == '0 && o_grad_v2_z == '0))
        else $error("zero rest area gave a nonzero result");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

    typedef stvk_pkg::t_word t_word;

    localparam int unsigned LatencyCycles = 13;
    localparam int unsigned CycleLimit    = 600000;
    localparam int unsigned RandomItems   = 1600;

    typedef struct {
        t_word          e1 [3];
        t_word          e2 [3];
        t_word          inv [4];
        logic [30:0]    area;
    } t_tri;

    typedef struct {
        t_word w [10];
    } t_grad;

    typedef struct {
        t_tri  shape;
        bit    typed;
        t_grad want;
    } t_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    t_word          i_edge1_x = '0, i_edge1_y = '0, i_edge1_z = '0;
    t_word          i_edge2_x = '0, i_edge2_y = '0, i_edge2_z = '0;
    t_word          i_inv_00 = '0, i_inv_01 = '0, i_inv_10 = '0, i_inv_11 = '0;
    logic [30:0]    i_rest_area = '0;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [7:0]     i_cfg_index = '0;
    logic [31:0]    i_cfg_data = '0;
    logic           o_result_valid;
    t_word          o_weighted_energy;
    t_word          o_grad_v0_x, o_grad_v1_x, o_grad_v2_x;
    t_word          o_grad_v0_y, o_grad_v1_y, o_grad_v2_y;
    t_word          o_grad_v0_z, o_grad_v1_z, o_grad_v2_z;

    stvk_triangle_energy_gradient_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    longint unsigned mu_model;
    longint unsigned bulk_model;
    t_grad           grad_queue [$];
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count = 0;
    t_row            directed_rows [$];

    string field_name [10] = '{"weighted_energy", "grad_v0_x", "grad_v1_x", "grad_v2_x",
        "grad_v0_y", "grad_v1_y", "grad_v2_y", "grad_v0_z", "grad_v1_z", "grad_v2_z"};

    function automatic longint round_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_shift(a * b, 16);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_grad svk_gradient(t_tri t);
        t_grad  g;
        longint f [3][2];
        longint p [3][2];
        longint a, b, c, d, ar, mu, kb;
        longint c00, c01, c11, s00, s01, s11, tr, qs, ts, en, d0, d1, d3, g1, g2;
        a = t.inv[0]; b = t.inv[1]; c = t.inv[2]; d = t.inv[3];
        ar = longint'(t.area);
        mu = longint'(mu_model);
        kb = longint'(bulk_model);
        c00 = 0; c01 = 0; c11 = 0;
        for (int r = 0; r < 3; r++) begin
            f[r][0] = clamp32(qmul(t.e1[r], a) + qmul(t.e2[r], c));
            f[r][1] = clamp32(qmul(t.e1[r], b) + qmul(t.e2[r], d));
            c00 += qmul(f[r][0], f[r][0]);
            c01 += qmul(f[r][0], f[r][1]);
            c11 += qmul(f[r][1], f[r][1]);
        end
        c00 = clamp32(c00); c01 = clamp32(c01); c11 = clamp32(c11);
        s00 = round_shift(c00 - 65536, 1);
        s11 = round_shift(c11 - 65536, 1);
        s01 = round_shift(c01, 1);
        tr = clamp32(s00 + s11);
        qs = clamp32(qmul(s00, s00) + 2 * qmul(s01, s01) + qmul(s11, s11));
        ts = clamp32(qmul(tr, tr));
        en = clamp32(qmul(mu, qs) + round_shift(kb * ts, 17));
        g.w[0] = t_word'(clamp32(qmul(ar, en)));
        d0 = clamp32(qmul(ar, clamp32(round_shift(2 * mu * s00 + kb * tr, 16))));
        d3 = clamp32(qmul(ar, clamp32(round_shift(2 * mu * s11 + kb * tr, 16))));
        d1 = clamp32(qmul(ar, clamp32(round_shift(2 * mu * s01, 16))));
        for (int r = 0; r < 3; r++) begin
            p[r][0] = clamp32(qmul(d0, f[r][0]) + qmul(d1, f[r][1]));
            p[r][1] = clamp32(qmul(d1, f[r][0]) + qmul(d3, f[r][1]));
            g1 = qmul(p[r][0], a) + qmul(p[r][1], b);
            g2 = qmul(p[r][0], c) + qmul(p[r][1], d);
            g.w[1 + 3 * r] = t_word'(clamp32(-(g1 + g2)));
            g.w[2 + 3 * r] = t_word'(clamp32(g1));
            g.w[3 + 3 * r] = t_word'(clamp32(g2));
        end
        return g;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_word got [10];
        t_grad exp_g;
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end else if (i_rst_n && o_result_valid) begin
            got = '{o_weighted_energy, o_grad_v0_x, o_grad_v1_x, o_grad_v2_x,
                    o_grad_v0_y, o_grad_v1_y, o_grad_v2_y,
                    o_grad_v0_z, o_grad_v1_z, o_grad_v2_z};
            if (grad_queue.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                exp_g = grad_queue.pop_front();
                for (int k = 0; k < 10; k++) begin
                    if (got[k] !== exp_g.w[k]) begin
                        report_mismatch($sformatf("%s got %h want %h",
                            field_name[k], got[k], exp_g.w[k]));
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == stvk_pkg::CfgShear) mu_model = data & 32'hFFFFFF;
        else if (idx == stvk_pkg::CfgBulk) bulk_model = data & 32'hFFFFFF;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (grad_queue.size() != 0) @(posedge i_clk);
        repeat (LatencyCycles + 4) @(posedge i_clk);
    endtask

    task automatic gap;
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_tri(t_tri t, bit typed, t_grad want);
        start <= 1'b1;
        i_edge1_x <= t.e1[0]; i_edge1_y <= t.e1[1]; i_edge1_z <= t.e1[2];
        i_edge2_x <= t.e2[0]; i_edge2_y <= t.e2[1]; i_edge2_z <= t.e2[2];
        i_inv_00 <= t.inv[0]; i_inv_01 <= t.inv[1];
        i_inv_10 <= t.inv[2]; i_inv_11 <= t.inv[3];
        i_rest_area <= t.area;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        grad_queue.push_back(typed ? want : svk_gradient(t));
    endtask

    function automatic t_word rand_word(int mode);
        case (mode)
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
            2: return t_word'(int'($urandom_range(0, 262144)) - 131072);
            default: return t_word'(int'($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int   m;
        m = $urandom_range(0, 9);
        m = (m < 5) ? 2 : (m < 7) ? 3 : (m < 9) ? 0 : 1;
        for (int r = 0; r < 3; r++) begin
            t.e1[r] = rand_word(($urandom_range(0, 7) == 0) ? 0 : m);
            t.e2[r] = rand_word(($urandom_range(0, 7) == 0) ? 0 : m);
        end
        for (int k = 0; k < 4; k++) t.inv[k] = rand_word(($urandom_range(0, 7) == 0) ? 0 : m);
        case ($urandom_range(0, 5))
            0: t.area = 31'($urandom);
            1: t.area = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
            default: t.area = 31'($urandom_range(0, 196608));
        endcase
        return t;
    endfunction

    function automatic t_tri make_tri(t_word ev, t_word iv, logic [30:0] ar);
        t_tri t;
        for (int r = 0; r < 3; r++) begin
            t.e1[r] = ev;
            t.e2[r] = -ev;
        end
        t.inv = '{iv, 0, 0, iv};
        t.area = ar;
        return t;
    endfunction

    task automatic add_row(t_tri t, bit typed, t_grad want);
        t_row row;
        row.shape = t;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic run_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            gap();
            send_tri(rand_tri(), 1'b0, '{default: '0});
        end
        start <= 1'b0;
    endtask

    initial begin
        t_grad zero_g;
        t_grad rest_g;
        t_tri  t;
        zero_g.w = '{default: '0};
        rest_g.w = '{default: '0};
        rest_g.w[0] = 32'sd58983;
        mu_model = stvk_pkg::ShearReset;
        bulk_model = stvk_pkg::BulkReset;

        add_row(make_tri(0, 0, 31'd0), 1'b1, zero_g);
        add_row(make_tri(0, 0, 31'd65536), 1'b1, rest_g);
        add_row(make_tri(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd0), 1'b1, zero_g);
        add_row(make_tri(32'sh8000_0000, 32'sh8000_0000, 31'd0), 1'b1, zero_g);
        add_row(make_tri(32'sd65536, 32'sd65536, 31'd65536), 1'b0, zero_g);
        add_row(make_tri(32'sd98304, 32'sd65536, 31'd32768), 1'b0, zero_g);
        add_row(make_tri(32'sd32768, 32'sd131072, 31'd65536), 1'b0, zero_g);
        add_row(make_tri(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF), 1'b0, zero_g);
        add_row(make_tri(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF), 1'b0, zero_g);
        add_row(make_tri(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF), 1'b0, zero_g);
        add_row(make_tri(32'sd1, 32'sd1, 31'd1), 1'b0, zero_g);
        add_row(make_tri(-32'sd1, -32'sd1, 31'd1), 1'b0, zero_g);
        t = make_tri(32'sd65536, 32'sd65536, 31'd65536);
        t.e1 = '{32'sd65536, 0, 0};
        t.e2 = '{0, 32'sd65536, 0};
        add_row(t, 1'b0, zero_g);
        t.e2 = '{0, 32'sd65536, 32'sd65536};
        t.inv = '{32'sd65536, -32'sd32768, 32'sd13107, 32'sd65536};
        add_row(t, 1'b0, zero_g);
        t.e1 = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
        t.inv = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
        t.area = 31'h7FFF_FFFF;
        add_row(t, 1'b0, zero_g);
        t.e1 = '{32'sd5, -32'sd7, 32'sd3};
        t.e2 = '{-32'sd2, 32'sd4, -32'sd9};
        t.inv = '{0, 0, 0, 0};
        t.area = 31'd65536;
        add_row(t, 1'b0, zero_g);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            gap();
            send_tri(directed_rows[i].shape, directed_rows[i].typed, directed_rows[i].want);
        end
        start <= 1'b0;
        drain();

        write_reg(stvk_pkg::CfgShear, 32'd0);
        write_reg(stvk_pkg::CfgBulk, 32'd0);
        run_random(RandomItems / 8);
        drain();

        write_reg(stvk_pkg::CfgShear, 32'hFFFF_FFFF);
        write_reg(stvk_pkg::CfgBulk, 32'h00FF_FFFF);
        run_random(RandomItems / 8);
        drain();

        write_reg(8'd2, 32'h0001_0000);
        write_reg(8'hFF, 32'h0000_1234);
        write_reg(stvk_pkg::CfgShear, 32'hAB01_0000);
        write_reg(stvk_pkg::CfgBulk, 32'h0002_8000);
        run_random(RandomItems / 4);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(stvk_pkg::CfgShear, $urandom_range(0, 262144));
            write_reg(stvk_pkg::CfgBulk, $urandom);
            run_random(RandomItems / 8);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
